[hdl/bts_pkg.sv]
package bts_pkg;

   // fixed field widths
   localparam int OP_W     = 3;
   localparam int TASK_W   = 5;
   localparam int TMO_W    = 16;
   localparam int STATUS_W = 3;

   // members per group, as an index width
   localparam int MEMBER_BITS = 2;
   localparam logic [MEMBER_BITS-1:0] MEMBER_MASK = 2'h3;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE   = 3'd0,
      OP_RESUME   = 3'd1,
      OP_SUSPEND  = 3'd2,
      OP_SCHEDULE = 3'd3,
      OP_TICK     = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_IDLE         = 3'd1,
      ST_NOT_CREATED  = 3'd2,
      ST_NONE_READY   = 3'd3,
      ST_LOCKED       = 3'd4,
      ST_NONE_PENDING = 3'd5,
      ST_NONE_EXPIRED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_UPDATE,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic scan_start;
      logic scan_step;
      logic rd_en;
      logic update;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_valid;
      logic tick_scan;
      logic out_free;
      logic scan_pend;
      logic scan_zero;
      logic expire;
      logic held_valid;
   } stat_type;

endpackage

[hdl/bitmap_task_scheduler.sv]
// channel  direction  signals                       contents
// req      in         req_tvalid/tready/tdata/tuser  one scheduler operation
// rsp      out        rsp_tvalid/tready/tdata/tlast  result transfers, tlast on the final one
//
// create, resume, suspend and schedule: accept, then a decode state that waits for a free
//   output slot and registers the result; the block is then ready again.
// tick: decode state, then the walk over the NT usable entries from the highest down, a
//   step per idle entry and a delay memory read, then an update, per pending entry, plus
//   a closing step; the walk runs only with the timer unlocked and a task pending.
// reset is synchronous and clears all bitmaps at once; no clearing pass.
// a stalled rsp holds the walk only where a further transfer must be loaded.
module bitmap_task_scheduler #(
   parameter int GROUPS     = 8,
   parameter int TASKS      = 32,
   parameter int DELAY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // task_req[4:0], timeout[20:5], timer_locked[21], zero
   input  logic [2:0]  req_tuser,  // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // task_out[4:0], status[7:5]
   output logic        rsp_tlast
);

   bts_pkg::cmd_type    cmd;
   bts_pkg::stat_type   st;
   logic [bts_pkg::TASK_W-1:0] rsp_task_out;
   bts_pkg::status_type rsp_status;

   bts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bts_dp #(
      .GROUPS     (GROUPS),
      .TASKS      (TASKS),
      .DELAY_BITS (DELAY_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_operation    (req_tuser),
      .req_task_req     (req_tdata[4:0]),
      .req_timeout      (req_tdata[20:5]),
      .req_timer_locked (req_tdata[21]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_task_out     (rsp_task_out),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_tlast)
   );

   assign rsp_tdata = {rsp_status, rsp_task_out};

`ifndef SYNTHESIS
   // single results only load into a free output slot
   a_exec_free: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> st.out_free) else $error("result loaded into busy slot");

   // an expiry that pushes out a held result needs a free slot
   a_update_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && st.expire && st.held_valid) |-> st.out_free)
      else $error("held result lost on expiry");

   // closing transfer only into a free slot
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> st.out_free) else $error("closing result lost");

   // an accepted request keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("request taken while busy");
`endif

endmodule

[hdl/bts_ctrl.sv]
module bts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  bts_pkg::stat_type  st,
   output bts_pkg::cmd_type   cmd
);

   bts_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bts_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bts_pkg::S_IDLE: begin
            if (req_tvalid) state_in = bts_pkg::S_EXEC;
         end
         bts_pkg::S_EXEC: begin
            if (st.tick_scan) state_in = bts_pkg::S_SCAN;
            else if (!st.op_valid) state_in = bts_pkg::S_IDLE;
            else if (st.out_free) state_in = bts_pkg::S_IDLE;
         end
         bts_pkg::S_SCAN: begin
            if (st.scan_pend) state_in = bts_pkg::S_UPDATE;
            else if (st.scan_zero) state_in = bts_pkg::S_FINISH;
         end
         bts_pkg::S_UPDATE: begin
            if (!(st.expire && st.held_valid && !st.out_free)) begin
               state_in = st.scan_zero ? bts_pkg::S_FINISH : bts_pkg::S_SCAN;
            end
         end
         bts_pkg::S_FINISH: begin
            if (st.out_free) state_in = bts_pkg::S_IDLE;
         end
         default: state_in = bts_pkg::S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bts_pkg::S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         bts_pkg::S_EXEC: begin
            if (st.tick_scan) cmd.scan_start = 1'b1;
            else if (st.op_valid && st.out_free) cmd.exec = 1'b1;
         end
         bts_pkg::S_SCAN: begin
            if (st.scan_pend) cmd.rd_en = 1'b1;
            else if (!st.scan_zero) cmd.scan_step = 1'b1;
         end
         bts_pkg::S_UPDATE: begin
            if (!(st.expire && st.held_valid && !st.out_free)) begin
               cmd.update    = 1'b1;
               cmd.scan_step = !st.scan_zero;
            end
         end
         bts_pkg::S_FINISH: begin
            cmd.finish = st.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

[hdl/bts_dp.sv]
module bts_dp #(
   parameter int GROUPS     = 8,
   parameter int TASKS      = 32,
   parameter int DELAY_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bts_pkg::cmd_type                    cmd,
   output bts_pkg::stat_type                   st,
   input  logic [bts_pkg::OP_W-1:0]            req_operation,
   input  logic [bts_pkg::TASK_W-1:0]          req_task_req,
   input  logic [bts_pkg::TMO_W-1:0]           req_timeout,
   input  logic                                req_timer_locked,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bts_pkg::TASK_W-1:0]          rsp_task_out,
   output bts_pkg::status_type                 rsp_status,
   output logic                                rsp_last
);

   // usable task entries and index widths
   localparam int NT  = (TASKS < 4 * GROUPS) ? TASKS : 4 * GROUPS;
   localparam int TW  = $clog2(NT);
   localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int NB  = 4 * GROUPS;
   localparam int MB  = bts_pkg::MEMBER_BITS;
   localparam int TKW = bts_pkg::TASK_W;

   // captured request
   logic [bts_pkg::OP_W-1:0] op_ff;
   logic [TKW-1:0]           task_ff;
   logic [DELAY_BITS-1:0]    tmo_ff;
   logic                     locked_ff;
   logic [31:0]              tmo_wide;

   // scheduler state
   logic [NT-1:0]  created_ff, created_in;
   logic [NT-1:0]  ready_ff, ready_in;
   logic [NT-1:0]  pend_ff, pend_in;
   logic [MB-1:0]  rr_ff [GROUPS];
   logic [MB-1:0]  rr_in [GROUPS];
   logic [NB-1:0]  ready_pad;

   // tick walk
   logic [TW-1:0]         scan_ff, scan_in;
   logic [TKW-1:0]        scan_task;
   logic                  held_valid_ff, held_valid_in;
   logic [TKW-1:0]        held_task_ff, held_task_in;
   logic [DELAY_BITS-1:0] delay_mem [NT];
   logic [DELAY_BITS-1:0] rd_data_ff;
   logic                  mem_wr;
   logic [TW-1:0]         mem_wa;
   logic [DELAY_BITS-1:0] mem_wd;
   logic                  expire;

   // result register
   logic                rsp_valid_ff;
   logic [TKW-1:0]      rsp_task_ff;
   bts_pkg::status_type rsp_status_ff;
   logic                rsp_last_ff;
   logic                out_free;

   // result and state actions
   logic                emit;
   logic [TKW-1:0]      emit_task;
   bts_pkg::status_type emit_status;
   logic                emit_last;
   logic                act_ready, act_drop, act_pend, act_rr, created_set;
   logic [TKW-1:0]      act_t;
   logic [MB-1:0]       act_rr_val;

   // request decode
   logic task_ok;
   logic created_bit;

   // schedule pick
   logic          found;
   logic [GW-1:0] sel_g;
   logic [3:0]    sel_mem;
   logic [MB-1:0] sel_pos;
   logic [MB-1:0] sel_m;
   logic [MB-1:0] cand;
   logic [TKW-1:0] sched_task;

   assign tmo_wide    = 32'(req_timeout);
   assign task_ok     = ({1'b0, task_ff} < (TKW + 1)'(NT));
   assign created_bit = created_ff[task_ff[TW-1:0]];
   assign scan_task   = TKW'(scan_ff);
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign expire      = (rd_data_ff == DELAY_BITS'(1)) && (scan_ff != '0)
                        && created_ff[scan_ff];

   // group view of the ready set
   always_comb begin
      ready_pad = '0;
      ready_pad[NT-1:0] = ready_ff;
   end

   // highest ready group, then next lower member after the round robin position
   always_comb begin
      found   = 1'b0;
      sel_g   = '0;
      sel_mem = '0;
      sel_pos = '0;
      sel_m   = '0;
      cand    = '0;
      for (int gi = 0; gi < GROUPS; gi++) begin
         if (|ready_pad[4*gi +: 4]) begin
            found   = 1'b1;
            sel_g   = GW'(gi);
            sel_mem = ready_pad[4*gi +: 4];
            sel_pos = rr_ff[gi];
         end
      end
      for (int k = 4; k >= 1; k--) begin
         cand = (sel_pos - MB'(k)) & bts_pkg::MEMBER_MASK;
         if (sel_mem[cand]) sel_m = cand;
      end
   end

   assign sched_task = (TKW'(sel_g) << MB) | TKW'(sel_m);

   // operation decode, tick update and result selection
   always_comb begin
      emit          = 1'b0;
      emit_task     = task_ff;
      emit_status   = bts_pkg::ST_OK;
      emit_last     = 1'b1;
      act_ready     = 1'b0;
      act_drop      = 1'b0;
      act_pend      = 1'b0;
      act_rr        = 1'b0;
      created_set   = 1'b0;
      act_t         = task_ff;
      act_rr_val    = sel_m;
      mem_wr        = 1'b0;
      mem_wa        = task_ff[TW-1:0];
      mem_wd        = tmo_ff;
      held_valid_in = held_valid_ff;
      held_task_in  = held_task_ff;

      if (cmd.exec) begin
         emit = 1'b1;
         unique case (op_ff)
            bts_pkg::OP_CREATE: begin
               if (task_ok) begin
                  created_set = 1'b1;
                  act_ready   = 1'b1;
               end else begin
                  emit_status = bts_pkg::ST_NOT_CREATED;
               end
            end
            bts_pkg::OP_RESUME: begin
               if (task_ff == '0) emit_status = bts_pkg::ST_IDLE;
               else if (!task_ok || !created_bit) emit_status = bts_pkg::ST_NOT_CREATED;
               else begin
                  act_ready = 1'b1;
                  act_drop  = 1'b1;
               end
            end
            bts_pkg::OP_SUSPEND: begin
               if (task_ff == '0) emit_status = bts_pkg::ST_IDLE;
               else if (!task_ok || !created_bit) emit_status = bts_pkg::ST_NOT_CREATED;
               else begin
                  act_pend = 1'b1;
                  mem_wr   = 1'b1;
               end
            end
            bts_pkg::OP_SCHEDULE: begin
               if (found) begin
                  act_rr    = 1'b1;
                  act_t     = sched_task;
                  emit_task = sched_task;
               end else begin
                  emit_task   = '0;
                  emit_status = bts_pkg::ST_NONE_READY;
               end
            end
            bts_pkg::OP_TICK: begin
               emit_task   = '0;
               emit_status = locked_ff ? bts_pkg::ST_LOCKED : bts_pkg::ST_NONE_PENDING;
            end
            default: emit = 1'b0;
         endcase
      end

      // one pending entry: count down, release on expiry
      if (cmd.update) begin
         if (rd_data_ff != '0) begin
            mem_wr = 1'b1;
            mem_wa = scan_ff;
            mem_wd = rd_data_ff - DELAY_BITS'(1);
         end
         if (expire) begin
            act_ready = 1'b1;
            act_drop  = 1'b1;
            act_t     = scan_task;
            if (held_valid_ff) begin
               emit        = 1'b1;
               emit_task   = held_task_ff;
               emit_last   = 1'b0;
            end
            held_valid_in = 1'b1;
            held_task_in  = scan_task;
         end
      end

      // end of walk: the held transfer, or a none-expired status, closes the run
      if (cmd.finish) begin
         emit          = 1'b1;
         emit_task     = held_valid_ff ? held_task_ff : '0;
         emit_status   = held_valid_ff ? bts_pkg::ST_OK : bts_pkg::ST_NONE_EXPIRED;
         held_valid_in = 1'b0;
      end

      if (cmd.scan_start) held_valid_in = 1'b0;
   end

   // bitmap and round robin next values
   always_comb begin
      created_in = created_ff;
      ready_in   = ready_ff;
      pend_in    = pend_ff;
      rr_in      = rr_ff;
      if (created_set) created_in[act_t[TW-1:0]] = 1'b1;
      if (act_ready) begin
         if (ready_pad[{act_t[TKW-1:MB], 2'b00} +: 4] == 4'h0) rr_in[act_t[GW+MB-1:MB]] = '0;
         ready_in[act_t[TW-1:0]] = 1'b1;
      end
      if (act_drop) pend_in[act_t[TW-1:0]] = 1'b0;
      if (act_pend) begin
         pend_in[act_t[TW-1:0]]  = 1'b1;
         ready_in[act_t[TW-1:0]] = 1'b0;
      end
      if (act_rr) rr_in[act_t[GW+MB-1:MB]] = act_rr_val;
   end

   // walk counter
   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_start) scan_in = TW'(NT - 1);
      else if (cmd.scan_step) scan_in = scan_ff - TW'(1);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         created_ff    <= '0;
         ready_ff      <= '0;
         pend_ff       <= '0;
         rr_ff         <= '{default: '0};
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_ff       <= '0;
      end else begin
         created_ff    <= created_in;
         ready_ff      <= ready_in;
         pend_ff       <= pend_in;
         rr_ff         <= rr_in;
         held_valid_ff <= held_valid_in;
         scan_ff       <= scan_in;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         task_ff   <= req_task_req;
         tmo_ff    <= tmo_wide[DELAY_BITS-1:0];
         locked_ff <= req_timer_locked;
      end
      held_task_ff <= held_task_in;
      if (emit) begin
         rsp_task_ff   <= emit_task;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
   end

   // delay memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_wr) delay_mem[mem_wa] <= mem_wd;
      if (cmd.rd_en) rd_data_ff <= delay_mem[scan_ff];
   end

   // status to controller
   assign st.op_valid   = (op_ff <= bts_pkg::OP_TICK);
   assign st.tick_scan  = (op_ff == bts_pkg::OP_TICK) && !locked_ff && (|pend_ff);
   assign st.out_free   = out_free;
   assign st.scan_pend  = pend_ff[scan_ff];
   assign st.scan_zero  = (scan_ff == '0);
   assign st.expire     = expire;
   assign st.held_valid = held_valid_ff;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_task_out = rsp_task_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

endmodule
